// File: rtl/nfa_epsilon_closure_matcher_macros.svh
// Assertion shorthands shared by the matcher.
`ifndef NFA_EPSILON_CLOSURE_MATCHER_MACROS_SVH
`define NFA_EPSILON_CLOSURE_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NFA_ECM_ASSERT_IMP(label, a_clk, a_rst_n, ante, cons) \
    label: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
        else $error("nfa_epsilon_closure_matcher: check failed");

// Next-cycle implication, disabled while reset is low.
`define NFA_ECM_ASSERT_NXT(label, a_clk, a_rst_n, ante, cons) \
    label: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
        else $error("nfa_epsilon_closure_matcher: check failed");

`endif

// File: rtl/nfa_ecm_pkg.sv
`timescale 1ns / 1ps

package nfa_ecm_pkg;

    localparam int SET_W     = 16;
    localparam int SYM_W     = 8;
    localparam int IDX_W     = 4;
    localparam int ACT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK   = 2'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_RESTART   = 3'd0,
        ACT_LOAD_MOVE = 3'd1,
        ACT_LOAD_EPS  = 3'd2,
        ACT_FEED      = 3'd3,
        ACT_END       = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLOSE,
        ST_MOVE,
        ST_MOVE_LAST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mtab_req_t;

    typedef struct packed {
        logic             load;
        logic             matched;
        logic [SET_W-1:0] final_set;
    } core_res_t;

endpackage

// File: rtl/nfa_ecm_mtab.sv
`timescale 1ns / 1ps

module nfa_ecm_mtab #(
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                               clk,
    input  nfa_ecm_pkg::mtab_req_t             req,
    input  logic [ADDR_W-1:0]                  addr,
    input  logic [nfa_ecm_pkg::SET_W-1:0]      wdata,
    output logic [nfa_ecm_pkg::SET_W-1:0]      rdata
);

    logic [nfa_ecm_pkg::SET_W-1:0] mem_reg [DEPTH];
    logic [nfa_ecm_pkg::SET_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[addr] <= wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/nfa_ecm_core.sv
`timescale 1ns / 1ps

module nfa_ecm_core #(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8,
    localparam int NS_EFF = (NUM_STATES < nfa_ecm_pkg::SET_W) ? NUM_STATES
                                                               : nfa_ecm_pkg::SET_W,
    localparam int SW     = $clog2(NS_EFF),
    localparam int MAW    = SW + SYMBOL_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [nfa_ecm_pkg::ACT_W-1:0]         action,
    input  logic [nfa_ecm_pkg::IDX_W-1:0]         state_index,
    input  logic [nfa_ecm_pkg::SYM_W-1:0]         symbol,
    input  logic [nfa_ecm_pkg::SET_W-1:0]         next_mask,
    input  logic [nfa_ecm_pkg::IDX_W-1:0]         initial_state,
    input  logic [nfa_ecm_pkg::SET_W-1:0]         accept_mask,
    input  logic                                  res_free,
    output nfa_ecm_pkg::core_res_t                res,
    output nfa_ecm_pkg::mtab_req_t                mem_req,
    output logic [MAW-1:0]                        mem_addr,
    output logic [nfa_ecm_pkg::SET_W-1:0]         mem_wdata,
    input  logic [nfa_ecm_pkg::SET_W-1:0]         mem_rdata
);

    localparam int DEPTH = NS_EFF << SYMBOL_BITS;
    localparam logic [nfa_ecm_pkg::SET_W-1:0] STATE_MASK =
        nfa_ecm_pkg::SET_W'((1 << NS_EFF) - 1);
    localparam logic [SW-1:0]  LAST_S = SW'(NS_EFF - 1);
    localparam logic [MAW-1:0] LAST_A = MAW'(DEPTH - 1);
    localparam logic [nfa_ecm_pkg::IDX_W:0] NS_LIM = (nfa_ecm_pkg::IDX_W + 1)'(NS_EFF);

    nfa_ecm_pkg::state_t state_reg, state_next;

    logic [SW-1:0]                 cnt_reg, cnt_next;
    logic [MAW-1:0]                clr_reg, clr_next;
    logic [nfa_ecm_pkg::SET_W-1:0] set_reg, set_next;
    logic [nfa_ecm_pkg::SET_W-1:0] acc_reg, acc_next;
    logic [SYMBOL_BITS-1:0]        sym_reg, sym_next;
    logic                          end_reg, end_next;
    logic                          chg_reg, chg_next;
    logic                          pend_reg, pend_next;
    logic [nfa_ecm_pkg::SET_W-1:0] eps_reg [NS_EFF];

    nfa_ecm_pkg::action_t          act;
    logic                          in_fire;
    logic                          idx_ok;
    logic                          eps_we;
    logic [SYMBOL_BITS-1:0]        sym_in;
    logic                          cur_on;
    logic [nfa_ecm_pkg::SET_W-1:0] grow;
    logic                          grows;
    logic                          pass_again;
    logic [nfa_ecm_pkg::SET_W-1:0] start_set;
    logic [nfa_ecm_pkg::SET_W-1:0] acc_sum;
    logic [nfa_ecm_pkg::SET_W-1:0] load_mask;

    assign act       = nfa_ecm_pkg::action_t'(action);
    assign in_ready  = (state_reg == nfa_ecm_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign idx_ok    = {1'b0, state_index} < NS_LIM;
    assign sym_in    = symbol[SYMBOL_BITS-1:0];
    assign load_mask = next_mask & STATE_MASK;

    // One state of the scan is merged per cycle; grow holds the bits it would add.
    assign cur_on     = set_reg[cnt_reg];
    assign grow       = cur_on ? (eps_reg[cnt_reg] & ~set_reg) : '0;
    assign grows      = |grow;
    assign pass_again = chg_reg || grows;

    // The initial state lies below sixteen, so the shift never leaves the word.
    assign start_set = (nfa_ecm_pkg::SET_W'(1) << initial_state) & STATE_MASK;
    assign acc_sum   = acc_reg | (pend_reg ? mem_rdata : '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfa_ecm_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_A)
                begin
                    state_next = nfa_ecm_pkg::ST_IDLE;
                end
            end
            nfa_ecm_pkg::ST_IDLE:
            begin
                if (in_fire && (act == nfa_ecm_pkg::ACT_FEED || act == nfa_ecm_pkg::ACT_END))
                begin
                    state_next = nfa_ecm_pkg::ST_CLOSE;
                end
            end
            nfa_ecm_pkg::ST_CLOSE:
            begin
                if (cnt_reg == LAST_S && !pass_again)
                begin
                    state_next = end_reg ? nfa_ecm_pkg::ST_DONE : nfa_ecm_pkg::ST_MOVE;
                end
            end
            nfa_ecm_pkg::ST_MOVE:
            begin
                if (cnt_reg == LAST_S)
                begin
                    state_next = nfa_ecm_pkg::ST_MOVE_LAST;
                end
            end
            nfa_ecm_pkg::ST_MOVE_LAST:
            begin
                state_next = nfa_ecm_pkg::ST_IDLE;
            end
            nfa_ecm_pkg::ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = nfa_ecm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfa_ecm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_req.wr_en = 1'b0;
        mem_req.rd_en = 1'b0;
        mem_addr      = {cnt_reg, sym_reg};
        mem_wdata     = '0;
        res.load      = 1'b0;
        res.matched   = |(set_reg & accept_mask);
        res.final_set = set_reg;
        unique case (state_reg)
            nfa_ecm_pkg::ST_CLEAR:
            begin
                mem_req.wr_en = 1'b1;
                mem_addr      = clr_reg;
            end
            nfa_ecm_pkg::ST_IDLE:
            begin
                if (in_fire && act == nfa_ecm_pkg::ACT_LOAD_MOVE && idx_ok)
                begin
                    mem_req.wr_en = 1'b1;
                    mem_addr      = {state_index[SW-1:0], sym_in};
                    mem_wdata     = load_mask;
                end
            end
            nfa_ecm_pkg::ST_MOVE:
            begin
                mem_req.rd_en = cur_on;
            end
            nfa_ecm_pkg::ST_DONE:
            begin
                res.load = res_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        clr_next  = clr_reg;
        set_next  = set_reg;
        acc_next  = acc_reg;
        sym_next  = sym_reg;
        end_next  = end_reg;
        chg_next  = chg_reg;
        pend_next = 1'b0;
        eps_we    = 1'b0;
        unique case (state_reg)
            nfa_ecm_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            nfa_ecm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (act)
                        nfa_ecm_pkg::ACT_RESTART:
                        begin
                            set_next = start_set;
                        end
                        nfa_ecm_pkg::ACT_LOAD_EPS:
                        begin
                            eps_we = idx_ok;
                        end
                        nfa_ecm_pkg::ACT_FEED:
                        begin
                            sym_next = sym_in;
                            end_next = 1'b0;
                            cnt_next = '0;
                            chg_next = 1'b0;
                        end
                        nfa_ecm_pkg::ACT_END:
                        begin
                            end_next = 1'b1;
                            cnt_next = '0;
                            chg_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            nfa_ecm_pkg::ST_CLOSE:
            begin
                set_next = set_reg | grow;
                if (cnt_reg == LAST_S)
                begin
                    // A pass with no growth means the set is closed.
                    cnt_next = '0;
                    chg_next = 1'b0;
                    acc_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    chg_next = pass_again;
                end
            end
            nfa_ecm_pkg::ST_MOVE:
            begin
                pend_next = cur_on;
                acc_next  = acc_sum;
                cnt_next  = (cnt_reg == LAST_S) ? '0 : cnt_reg + 1'b1;
            end
            nfa_ecm_pkg::ST_MOVE_LAST:
            begin
                set_next = acc_sum;
            end
            nfa_ecm_pkg::ST_DONE:
            begin
                if (res_free)
                begin
                    set_next = start_set;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfa_ecm_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            set_reg   <= nfa_ecm_pkg::SET_W'(1);
            end_reg   <= 1'b0;
            chg_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            set_reg   <= set_next;
            end_reg   <= end_next;
            chg_reg   <= chg_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sym_reg <= sym_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS_EFF; i++)
            begin
                eps_reg[i] <= '0;
            end
        end
        else if (eps_we)
        begin
            eps_reg[state_index[SW-1:0]] <= load_mask;
        end
    end

endmodule

// File: rtl/nfa_epsilon_closure_matcher.sv
`timescale 1ns / 1ps
// Byte-stream automaton matcher. Input beats carry an action with its operands:
// restart, load a move-table entry, load an epsilon entry, feed a byte, or end
// the string. Only an end beat gives an output beat (matched, final_set).
// Loads and restart leave the block ready for the next beat. A fed byte runs
// closure passes over the states (at most sixteen), then the move step and a
// last step that stores the new set; an end beat runs closure passes, then
// hands over its result. One state is merged per cycle by a single OR unit,
// and passes repeat until one adds nothing, so there is at least one. The move
// step reads the move memory once per active state through its single port.
// After reset the move memory is swept to zero, one entry a cycle, over all its
// min(NUM_STATES, 16) << SYMBOL_BITS entries (4096 by default), during which
// in_ready is low; configuration writes are taken throughout. The active set
// then holds state 0 only, until a restart or a result loads the start state.
// The result sits in an output register, so the next item is taken while it
// waits. If the receiver still holds back an earlier result when a new end beat
// finishes, the block waits with in_ready low until that slot frees. The user
// writes configuration via cfg_we, cfg_index, cfg_data while idle; not enforced.

`include "nfa_epsilon_closure_matcher_macros.svh"

module nfa_epsilon_closure_matcher #(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [nfa_ecm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nfa_ecm_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [nfa_ecm_pkg::ACT_W-1:0]         action,
    input  logic [nfa_ecm_pkg::IDX_W-1:0]         state_index,
    input  logic [nfa_ecm_pkg::SYM_W-1:0]         symbol,
    input  logic [nfa_ecm_pkg::SET_W-1:0]         next_mask,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  matched,
    output logic [nfa_ecm_pkg::SET_W-1:0]         final_set
);

    localparam int NS_EFF = (NUM_STATES < nfa_ecm_pkg::SET_W) ? NUM_STATES
                                                               : nfa_ecm_pkg::SET_W;
    localparam int SW     = $clog2(NS_EFF);
    localparam int MAW    = SW + SYMBOL_BITS;
    localparam int DEPTH  = NS_EFF << SYMBOL_BITS;
    localparam logic [nfa_ecm_pkg::SET_W-1:0] STATE_MASK =
        nfa_ecm_pkg::SET_W'((1 << NS_EFF) - 1);

    logic [nfa_ecm_pkg::IDX_W-1:0] initial_state_reg;
    logic [nfa_ecm_pkg::SET_W-1:0] accept_mask_reg;
    logic                          out_valid_reg;
    logic                          matched_reg;
    logic [nfa_ecm_pkg::SET_W-1:0] final_set_reg;

    nfa_ecm_pkg::core_res_t        core_res;
    nfa_ecm_pkg::mtab_req_t        mem_req;
    logic [MAW-1:0]                mem_addr;
    logic [nfa_ecm_pkg::SET_W-1:0] mem_wdata;
    logic [nfa_ecm_pkg::SET_W-1:0] mem_rdata;
    logic                          res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_state_reg <= '0;
            accept_mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nfa_ecm_pkg::CFG_INITIAL_STATE:
                begin
                    initial_state_reg <= cfg_data[nfa_ecm_pkg::IDX_W-1:0];
                end
                nfa_ecm_pkg::CFG_ACCEPT_MASK:
                begin
                    accept_mask_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res_free = !out_valid_reg || out_ready;

    nfa_ecm_core #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .state_index   (state_index),
        .symbol        (symbol),
        .next_mask     (next_mask),
        .initial_state (initial_state_reg),
        .accept_mask   (accept_mask_reg),
        .res_free      (res_free),
        .res           (core_res),
        .mem_req       (mem_req),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata)
    );

    nfa_ecm_mtab #(
        .DEPTH (DEPTH)
    ) u_mtab (
        .clk   (clk),
        .req   (mem_req),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res.load)
        begin
            matched_reg   <= core_res.matched;
            final_set_reg <= core_res.final_set;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign final_set = final_set_reg;

    // A new result never overwrites a beat the receiver has not yet taken.
    `NFA_ECM_ASSERT_IMP(a_res_slot_free, clk, rst_n, core_res.load, !out_valid_reg || out_ready)
    // A feed or end beat starts a multi-cycle walk, so the block is busy next cycle.
    `NFA_ECM_ASSERT_NXT(a_busy_after_walk, clk, rst_n, in_valid && in_ready && (action == nfa_ecm_pkg::ACT_FEED || action == nfa_ecm_pkg::ACT_END), !in_ready)
    // The reported set never holds a state beyond the automaton.
    `NFA_ECM_ASSERT_IMP(a_set_in_range, clk, rst_n, out_valid_reg, (final_set_reg & ~STATE_MASK) == '0)
    // The single memory port is never asked to read and write at once.
    `NFA_ECM_ASSERT_IMP(a_one_port_op, clk, rst_n, mem_req.wr_en, !mem_req.rd_en)

endmodule

// File: tb/nfa_epsilon_closure_matcher_test.sv
`timescale 1ns / 1ps

module nfa_epsilon_closure_matcher_test;

    localparam int ACT_W     = nfa_ecm_pkg::ACT_W;
    localparam int IDX_W     = nfa_ecm_pkg::IDX_W;
    localparam int SYM_W     = nfa_ecm_pkg::SYM_W;
    localparam int SET_W     = nfa_ecm_pkg::SET_W;
    localparam int CFG_IDX_W = nfa_ecm_pkg::CFG_IDX_W;
    localparam int CFG_W     = nfa_ecm_pkg::CFG_W;

    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 800;
    localparam int PHASE_BEATS   = 85;

    localparam logic [ACT_W-1:0]     ACT_RSVD_5 = 3'd5;
    localparam logic [ACT_W-1:0]     ACT_RSVD_6 = 3'd6;
    localparam logic [ACT_W-1:0]     ACT_RSVD_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD_3 = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [IDX_W-1:0] idx;
        logic [SYM_W-1:0] sym;
        logic [SET_W-1:0] mask;
    } cmd_t;

    typedef struct packed {
        logic             matched;
        logic [SET_W-1:0] fset;
    } verdict_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [ACT_W-1:0]     action      = '0;
    logic [IDX_W-1:0]     state_index = '0;
    logic [SYM_W-1:0]     symbol      = '0;
    logic [SET_W-1:0]     next_mask   = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic                 matched;
    logic [SET_W-1:0]     final_set;

    // Golden copy of the matcher state and its two registers.
    logic [SET_W-1:0] mv_tab [0:(1 << (IDX_W + SYM_W)) - 1];
    logic [SET_W-1:0] eps_tab [0:SET_W-1];
    logic [SET_W-1:0] act_set;
    logic [IDX_W-1:0] start_idx;
    logic [SET_W-1:0] acc_mask;

    cmd_t     cmd_q [$];
    verdict_t verdict_q [$];
    cmd_t     offer;
    cmd_t     taken;
    verdict_t due_res;
    verdict_t seen_res;
    logic     took_cmd = 1'b0;

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_len      = 0;
    int hold_tag      = 0;
    int hold_tag_seen = 0;
    int hold_left     = 0;
    int mismatch_cnt  = 0;
    int quiet_cycles  = 0;

    nfa_epsilon_closure_matcher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .state_index (state_index),
        .symbol      (symbol),
        .next_mask   (next_mask),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .matched     (matched),
        .final_set   (final_set)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [SET_W-1:0] start_set();
        logic [SET_W-1:0] s;
        s = '0;
        s[start_idx] = 1'b1;
        return s;
    endfunction

    // Widen a set until a whole pass over the states adds nothing.
    function automatic logic [SET_W-1:0] eps_close(input logic [SET_W-1:0] s);
        logic [SET_W-1:0] prev;
        do
        begin
            prev = s;
            for (int i = 0; i < SET_W; i++)
                if (s[i])
                    s |= eps_tab[i];
        end while (s != prev);
        return s;
    endfunction

    function automatic logic [SET_W-1:0] take_byte(input logic [SET_W-1:0] s,
                                                   input logic [SYM_W-1:0] c);
        logic [SET_W-1:0] nx;
        nx = '0;
        for (int i = 0; i < SET_W; i++)
            if (s[i])
                nx |= mv_tab[(i << SYM_W) | c];
        return nx;
    endfunction

    task automatic advance_matcher(input cmd_t b);
        verdict_t r;
        case (b.act)
            nfa_ecm_pkg::ACT_RESTART:   act_set = start_set();
            nfa_ecm_pkg::ACT_LOAD_MOVE: mv_tab[{b.idx, b.sym}] = b.mask;
            nfa_ecm_pkg::ACT_LOAD_EPS:  eps_tab[b.idx] = b.mask;
            nfa_ecm_pkg::ACT_FEED:      act_set = take_byte(eps_close(act_set), b.sym);
            nfa_ecm_pkg::ACT_END:
            begin
                r.fset    = eps_close(act_set);
                r.matched = |(r.fset & acc_mask);
                verdict_q.push_back(r);
                act_set   = start_set();
            end
            default: ;
        endcase
    endtask

    task automatic add_cmd(input logic [ACT_W-1:0] a, input logic [IDX_W-1:0] i,
                           input logic [SYM_W-1:0] c, input logic [SET_W-1:0] m);
        cmd_t b;
        b.act  = a;
        b.idx  = i;
        b.sym  = c;
        b.mask = m;
        cmd_q.push_back(b);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        if (r == nfa_ecm_pkg::CFG_INITIAL_STATE)
            start_idx = v[IDX_W-1:0];
        else if (r == nfa_ecm_pkg::CFG_ACCEPT_MASK)
            acc_mask = v[SET_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits out every pending command and result, then the longest item time,
    // since loads and feeds give nothing back to wait for.
    task automatic wait_drained();
        while (cmd_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [SET_W-1:0] few_targets();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'h0001 << $urandom_range(0, SET_W - 1);
            2:       return (16'h0001 << $urandom_range(0, SET_W - 1))
                            | (16'h0001 << $urandom_range(0, SET_W - 1));
            default: return SET_W'($urandom & $urandom & $urandom);
        endcase
    endfunction

    // A small automaton around a handful of busy states and a four-byte
    // alphabet, then words over it; some noise and stray bytes mixed in.
    task automatic queue_program(input int n_beats);
        logic [SYM_W-1:0] alpha [4];
        logic [IDX_W-1:0] hot [4];
        logic [SYM_W-1:0] c;
        int cnt;
        int len;
        int roll;
        cnt    = 0;
        hot[0] = start_idx;
        for (int k = 0; k < 4; k++)
        begin
            alpha[k] = SYM_W'($urandom_range(0, 255));
            if (k > 0)
                hot[k] = IDX_W'($urandom_range(0, 15));
        end
        repeat ($urandom_range(2, 5))
        begin
            add_cmd(nfa_ecm_pkg::ACT_LOAD_EPS,
                    ($urandom_range(0, 1) != 0) ? hot[$urandom_range(0, 3)]
                    : IDX_W'($urandom_range(0, 15)),
                    SYM_W'($urandom_range(0, 255)), few_targets());
            cnt++;
        end
        repeat ($urandom_range(6, 14))
        begin
            add_cmd(nfa_ecm_pkg::ACT_LOAD_MOVE,
                    ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 3)]
                    : IDX_W'($urandom_range(0, 15)), alpha[$urandom_range(0, 3)],
                    (16'h0001 << hot[$urandom_range(0, 3)]) | few_targets());
            cnt++;
        end
        while (cnt < n_beats)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                add_cmd(ACT_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 15)),
                        SYM_W'($urandom_range(0, 255)), SET_W'($urandom));
                if (cmd_q[$].act <= nfa_ecm_pkg::ACT_END)
                    cnt++;
            end
            else if (roll < 16)
            begin
                add_cmd(roll < 13 ? nfa_ecm_pkg::ACT_LOAD_MOVE : nfa_ecm_pkg::ACT_LOAD_EPS,
                        hot[$urandom_range(0, 3)], alpha[$urandom_range(0, 3)],
                        few_targets());
                cnt++;
            end
            else
            begin
                len = $urandom_range(0, 6);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        add_cmd(nfa_ecm_pkg::ACT_RESTART, IDX_W'($urandom_range(0, 15)),
                                SYM_W'($urandom_range(0, 255)), SET_W'($urandom));
                        cnt++;
                    end
                    c = ($urandom_range(0, 6) == 0) ? SYM_W'($urandom_range(0, 255))
                        : alpha[$urandom_range(0, 3)];
                    add_cmd(nfa_ecm_pkg::ACT_FEED, IDX_W'($urandom_range(0, 15)), c,
                            SET_W'($urandom));
                    cnt++;
                end
                add_cmd(nfa_ecm_pkg::ACT_END, IDX_W'($urandom_range(0, 15)),
                        SYM_W'($urandom_range(0, 255)), SET_W'($urandom));
                cnt++;
            end
        end
    endtask

    task automatic run_phase(input logic [IDX_W-1:0] init, input logic [SET_W-1:0] acc,
                             input int snd, input int rcv, input int hold);
        wait_drained();
        write_reg(nfa_ecm_pkg::CFG_INITIAL_STATE, CFG_W'(init));
        write_reg(nfa_ecm_pkg::CFG_ACCEPT_MASK, acc);
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        hold_len      = hold;
        hold_tag      = hold_tag + 1;
        queue_program(PHASE_BEATS);
    endtask

    initial
    begin
        for (int i = 0; i < (1 << (IDX_W + SYM_W)); i++)
            mv_tab[i] = '0;
        for (int i = 0; i < SET_W; i++)
            eps_tab[i] = '0;
        start_idx = '0;
        acc_mask  = '0;
        act_set   = start_set();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The block sweeps its move memory now, but register writes still land.
        write_reg(CFG_RSVD_2, 16'hFFFF);
        write_reg(CFG_RSVD_3, 16'h000F);
        write_reg(nfa_ecm_pkg::CFG_INITIAL_STATE, 16'h0000);
        write_reg(nfa_ecm_pkg::CFG_ACCEPT_MASK, 16'h0021);

        add_cmd(nfa_ecm_pkg::ACT_END, 4'd0, 8'h00, 16'h0000);
        add_cmd(nfa_ecm_pkg::ACT_LOAD_EPS, 4'd0, 8'h00, 16'h0006);
        add_cmd(nfa_ecm_pkg::ACT_LOAD_EPS, 4'd2, 8'h00, 16'h8000);
        // Backward links force the closure into further passes.
        add_cmd(nfa_ecm_pkg::ACT_LOAD_EPS, 4'd15, 8'h00, 16'h0010);
        add_cmd(nfa_ecm_pkg::ACT_LOAD_EPS, 4'd4, 8'h00, 16'h0008);
        add_cmd(nfa_ecm_pkg::ACT_LOAD_MOVE, 4'd15, 8'hFF, 16'h0020);
        add_cmd(nfa_ecm_pkg::ACT_LOAD_MOVE, 4'd3, 8'h00, 16'h8000);
        add_cmd(nfa_ecm_pkg::ACT_FEED, 4'd0, 8'hFF, 16'h0000);
        add_cmd(nfa_ecm_pkg::ACT_END, 4'd0, 8'h00, 16'h0000);
        add_cmd(nfa_ecm_pkg::ACT_FEED, 4'd0, 8'h00, 16'h0000);
        add_cmd(nfa_ecm_pkg::ACT_END, 4'd0, 8'h00, 16'h0000);
        // A byte with no transition empties the set, which then stays empty.
        add_cmd(nfa_ecm_pkg::ACT_FEED, 4'd0, 8'h55, 16'h0000);
        add_cmd(nfa_ecm_pkg::ACT_FEED, 4'd0, 8'h00, 16'h0000);
        add_cmd(nfa_ecm_pkg::ACT_END, 4'd0, 8'h00, 16'h0000);
        add_cmd(nfa_ecm_pkg::ACT_FEED, 4'd0, 8'hFF, 16'h0000);
        add_cmd(nfa_ecm_pkg::ACT_RESTART, 4'd0, 8'h00, 16'h0000);
        add_cmd(nfa_ecm_pkg::ACT_END, 4'd0, 8'h00, 16'h0000);
        add_cmd(ACT_RSVD_5, 4'd15, 8'hFF, 16'hFFFF);
        add_cmd(ACT_RSVD_6, 4'd0, 8'h00, 16'h0000);
        add_cmd(ACT_RSVD_7, 4'd10, 8'hAA, 16'h5555);
        add_cmd(nfa_ecm_pkg::ACT_LOAD_EPS, 4'd15, 8'hFF, 16'hFFFF);
        add_cmd(nfa_ecm_pkg::ACT_END, 4'd15, 8'hFF, 16'hFFFF);
        add_cmd(nfa_ecm_pkg::ACT_LOAD_EPS, 4'd15, 8'h00, 16'h0000);
        add_cmd(nfa_ecm_pkg::ACT_LOAD_MOVE, 4'd0, 8'h00, 16'hFFFF);
        add_cmd(nfa_ecm_pkg::ACT_FEED, 4'd0, 8'h00, 16'h0000);
        add_cmd(nfa_ecm_pkg::ACT_END, 4'd0, 8'h00, 16'h0000);

        run_phase(4'd15, 16'hFFFF, 0, 0, 0);
        run_phase(IDX_W'($urandom_range(0, 15)), SET_W'($urandom_range(0, 65535)), 67, 0, 0);
        run_phase(4'd0, 16'h0000, 0, 67, HOLD_CYCLES);
        run_phase(IDX_W'($urandom_range(0, 15)), SET_W'($urandom_range(0, 65535)), 27, 27, 0);
        run_phase(IDX_W'($urandom_range(0, 15)), SET_W'($urandom_range(0, 65535)), 0, 0, 0);

        wait_drained();
        if (mismatch_cnt == 0 && verdict_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Command driver: a beat stays on the port until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || took_cmd))
        begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct)
            begin
                offer = cmd_q.pop_front();
                in_valid    <= 1'b1;
                action      <= offer.act;
                state_index <= offer.idx;
                symbol      <= offer.sym;
                next_mask   <= offer.mask;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // A new phase may ask for a long hold, which this process counts down itself.
    always @(negedge clk)
    begin
        if (hold_tag != hold_tag_seen)
        begin
            hold_tag_seen = hold_tag;
            hold_left     = hold_len;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_cmd <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                taken = {action, state_index, symbol, next_mask};
                advance_matcher(taken);
            end
            if (out_valid && out_ready)
            begin
                seen_res.matched = matched;
                seen_res.fset    = final_set;
                if (verdict_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result beat: matched=%0b final_set=%h",
                                 seen_res.matched, seen_res.fset);
                end
                else
                begin
                    due_res = verdict_q.pop_front();
                    if (due_res.matched !== seen_res.matched || due_res.fset !== seen_res.fset)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("result mismatch: expected matched=%0b final_set=%h, %s",
                                     due_res.matched, due_res.fset,
                                     $sformatf("got matched=%0b final_set=%h",
                                               seen_res.matched, seen_res.fset));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
            quiet_cycles = quiet_cycles + 1;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
